// File: sv/tsa_pkg.sv
// Shared types and constants of the tagged slot allocator.
// Used by tsa_mem_pool and tagged_slot_allocator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

	// Default pool sizes.
	localparam int TSA_REGISTER_SLOTS = 16;
	localparam int TSA_MEMORY_SLOTS   = 256;

	// Field widths.
	localparam int KEY_W      = 64;
	localparam int TAG_W      = 2;
	localparam int KIND_W     = 2;
	localparam int IDX_OUT_W  = 8;
	localparam int REG_CNT_W  = 5;
	localparam int MEM_CNT_W  = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// Configuration register reset values.
	localparam logic [REG_CNT_W-1:0] REG_CNT_RESET = REG_CNT_W'(16);
	localparam logic [MEM_CNT_W-1:0] MEM_CNT_RESET = MEM_CNT_W'(256);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_REG_SLOTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_SLOTS = 1'b1;

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	// Slot tag codes.
	localparam logic [TAG_W-1:0] TAG_EMPTY    = 2'd0;
	localparam logic [TAG_W-1:0] TAG_VARIABLE = 2'd1;
	localparam logic [TAG_W-1:0] TAG_IMMED    = 2'd2;

	// Contents of one slot.
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
	} slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// File: sv/tsa_mem_pool.sv
// Memory pool storage: one write port, one registered read port and a tag
// clearing sweep after reset. Depends on tsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsa_mem_pool #(
	parameter int DEPTH  = tsa_pkg::TSA_MEMORY_SLOTS,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	output tsa_pkg::slot_t           rd_data,
	input  wire logic                wr_en,
	input  wire logic [ADDR_W-1:0]   wr_addr,
	input  wire tsa_pkg::slot_t      wr_data,
	output logic                     busy
);
	import tsa_pkg::*;

	logic [TAG_W-1:0] tag_mem [DEPTH];
	logic [KEY_W-1:0] key_mem [DEPTH];

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              tag_we;
	logic [ADDR_W-1:0] tag_addr;
	logic [TAG_W-1:0]  tag_wdata;

	// The sweep owns the tag write port until every tag reads empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	always_comb begin
		tag_we    = clr_busy_q || wr_en;
		tag_addr  = clr_busy_q ? clr_addr_q : wr_addr;
		tag_wdata = clr_busy_q ? TAG_EMPTY : wr_data.tag;
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_addr] <= tag_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !clr_busy_q) begin
			key_mem[wr_addr] <= wr_data.key;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data.tag <= tag_mem[rd_addr];
			rd_data.key <= key_mem[rd_addr];
		end
	end

	assign busy = clr_busy_q;

endmodule

`default_nettype wire

// File: sv/tagged_slot_allocator.sv
// Top level of the tagged slot allocator: sequencer, register pool, shared
// slot comparator and output register. Depends on tsa_pkg and tsa_mem_pool.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        receive    in_valid / in_stall    kind, pool, entry_tag, key
// out       send       out_valid / out_stall  success, slot_index
// cfg       receive    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each transaction scans its pool one slot per cycle through a single comparator. The scan
// ends at the first hit, or once every slot in use has been read without one; the result
// state and then the idle state follow, and in_stall holds off the next transaction until
// the sequencer is idle again. The result state waits while out_stall holds a full output
// register. After reset, in_stall also stays high while the memory pool tags are swept
// empty. A new transaction is taken while an earlier result waits under out_stall.

module tagged_slot_allocator #(
	parameter int REGISTER_SLOTS = tsa_pkg::TSA_REGISTER_SLOTS,
	parameter int MEMORY_SLOTS   = tsa_pkg::TSA_MEMORY_SLOTS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Request channel.
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [tsa_pkg::KIND_W-1:0]        kind,
	input  wire logic                              pool,
	input  wire logic                              entry_tag,
	input  wire logic [tsa_pkg::KEY_W-1:0]         key,
	// Result channel.
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   success,
	output logic [tsa_pkg::IDX_OUT_W-1:0]          slot_index,
	// Configuration write channel.
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tsa_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tsa_pkg::*;

	// Index widths of the two pools.
	localparam int RIDX_W = (REGISTER_SLOTS > 1) ? $clog2(REGISTER_SLOTS) : 1;
	localparam int MIDX_W = (MEMORY_SLOTS > 1) ? $clog2(MEMORY_SLOTS) : 1;
	// The scan counter must hold either pool size and the memory pool register value.
	localparam int RC_W   = $clog2(REGISTER_SLOTS + 1);
	localparam int MC_W   = $clog2(MEMORY_SLOTS + 1);
	localparam int RM_W   = (RC_W > MC_W) ? RC_W : MC_W;
	localparam int CNT_W  = (RM_W > MEM_CNT_W) ? RM_W : MEM_CNT_W;

	// Configuration registers.
	logic [REG_CNT_W-1:0] reg_cnt_q;
	logic [MEM_CNT_W-1:0] mem_cnt_q;

	// Sequencer state and the request being worked on.
	state_t             state_q, state_d;
	logic [KIND_W-1:0]  kind_q;
	logic               pool_q;
	logic [TAG_W-1:0]   want_q;
	logic [KEY_W-1:0]   key_q;
	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   rd_idx_q;

	// Compare stage: the slot read in the previous cycle.
	logic               cmp_valid_s1;
	logic [CNT_W-1:0]   cmp_idx_s1;
	slot_t              reg_rd_s1;

	// Result waiting to be loaded, and the output register.
	logic                 res_ok_q;
	logic [IDX_OUT_W-1:0] res_idx_q;
	logic                 out_valid_q;
	logic                 success_q;
	logic [IDX_OUT_W-1:0] slot_index_q;

	// Register pool.
	logic [TAG_W-1:0] reg_tag_q [REGISTER_SLOTS];
	logic [KEY_W-1:0] reg_key_q [REGISTER_SLOTS];

	// Memory pool interface.
	slot_t mem_rd_data;
	slot_t wr_data;
	logic  mem_busy;

	logic             in_acc;
	logic             out_free;
	logic             rd_issue;
	logic             hit;
	logic             wr_go;
	slot_t            cur;
	logic [CNT_W-1:0] reg_lim;
	logic [CNT_W-1:0] mem_lim;
	logic [TAG_W-1:0] in_want;

	assign in_stall  = (state_q != ST_IDLE) || mem_busy;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// A count above the pool size saturates to the pool size.
	always_comb begin
		reg_lim = (CNT_W'(reg_cnt_q) > CNT_W'(REGISTER_SLOTS)) ?
			CNT_W'(REGISTER_SLOTS) : CNT_W'(reg_cnt_q);
		mem_lim = (CNT_W'(mem_cnt_q) > CNT_W'(MEMORY_SLOTS)) ?
			CNT_W'(MEMORY_SLOTS) : CNT_W'(mem_cnt_q);
		in_want = entry_tag ? TAG_IMMED : TAG_VARIABLE;
	end

	// The shared comparator looks at one slot per cycle. A store hunts for
	// an empty tag; clear and search hunt for a matching tag and key.
	always_comb begin
		rd_issue = (state_q == ST_SCAN) && (rd_idx_q < limit_q);
		cur      = pool_q ? mem_rd_data : reg_rd_s1;
		if (kind_q == KIND_STORE) begin
			hit = cmp_valid_s1 && (cur.tag == TAG_EMPTY);
		end else begin
			hit = cmp_valid_s1 && (cur.tag == want_q) && (cur.key == key_q);
		end
		wr_go = (state_q == ST_SCAN) && hit && (kind_q != KIND_SEARCH);
		if (kind_q == KIND_STORE) begin
			wr_data.tag = want_q;
			wr_data.key = key_q;
		end else begin
			wr_data.tag = TAG_EMPTY;
			wr_data.key = '0;
		end
	end

	// Next state. The scan ends at the first hit, or once every slot in use
	// has been read and compared without one.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (kind == KIND_STORE || kind == KIND_CLEAR || kind == KIND_SEARCH) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				if (hit || (!cmp_valid_s1 && !rd_issue)) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_cnt_q <= REG_CNT_RESET;
			mem_cnt_q <= MEM_CNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_REG_SLOTS) begin
				reg_cnt_q <= cfg_data[REG_CNT_W-1:0];
			end else if (cfg_index == CFG_MEM_SLOTS) begin
				mem_cnt_q <= cfg_data[MEM_CNT_W-1:0];
			end
		end
	end

	// Scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
		end else if (in_acc) begin
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (rd_issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			cmp_valid_s1 <= rd_issue && !hit;
		end else begin
			cmp_valid_s1 <= 1'b0;
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q    <= kind;
			pool_q    <= pool;
			want_q    <= in_want;
			key_q     <= key;
			limit_q   <= pool ? mem_lim : reg_lim;
			res_ok_q  <= 1'b0;
			res_idx_q <= '0;
		end else if (state_q == ST_SCAN && hit) begin
			res_ok_q  <= 1'b1;
			res_idx_q <= cmp_idx_s1[IDX_OUT_W-1:0];
		end
		if (rd_issue) begin
			cmp_idx_s1 <= rd_idx_q;
		end
		if (rd_issue && !pool_q) begin
			reg_rd_s1.tag <= reg_tag_q[rd_idx_q[RIDX_W-1:0]];
			reg_rd_s1.key <= reg_key_q[rd_idx_q[RIDX_W-1:0]];
		end
	end

	// Register pool write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REGISTER_SLOTS; i++) begin
				reg_tag_q[i] <= TAG_EMPTY;
			end
		end else if (wr_go && !pool_q) begin
			reg_tag_q[cmp_idx_s1[RIDX_W-1:0]] <= wr_data.tag;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go && !pool_q) begin
			reg_key_q[cmp_idx_s1[RIDX_W-1:0]] <= wr_data.key;
		end
	end

	tsa_mem_pool #(
		.DEPTH  (MEMORY_SLOTS),
		.ADDR_W (MIDX_W)
	) u_mem_pool (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_issue && pool_q),
		.rd_addr (rd_idx_q[MIDX_W-1:0]),
		.rd_data (mem_rd_data),
		.wr_en   (wr_go && pool_q),
		.wr_addr (cmp_idx_s1[MIDX_W-1:0]),
		.wr_data (wr_data),
		.busy    (mem_busy)
	);

	// Output register: loaded from the finished result once it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			success_q    <= res_ok_q;
			slot_index_q <= res_idx_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign slot_index = slot_index_q;

`ifndef SYNTHESIS
	// No request is taken while the memory pool is still being swept.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !in_acc)
		else $error("request accepted during memory pool sweep");

	// A compared slot always lies inside the scanned range.
	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cmp_valid_s1) |-> (cmp_idx_s1 < limit_q))
		else $error("slot compared outside the slots in use");

	// An accepted request always starts work.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("accepted request was dropped");

	// A finished result waits while the output register is still held.
	a_resp_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && out_valid_q && out_stall) |=> (state_q == ST_RESP))
		else $error("result left before the output register was free");
`endif

endmodule

`default_nettype wire
